// ----- sv/cds_pkg.sv -----
package cds_pkg;

   localparam int YEAR_W     = 17;
   localparam int DAY_W      = 5;
   localparam int MONTH_W    = 4;
   localparam int LOAD_DAY_W = 6;
   localparam int DN_W       = 26;
   localparam int C100_W     = 7;
   localparam int Q100_W     = 11;
   localparam int MOFF_W     = 9;

   localparam logic [YEAR_W-1:0] DEFAULT_YEAR = 17'd2000;

   // floor(y / 100) for y < 2^17 is (y * 5242) >> 19, or one less
   localparam int RECIP100       = 5242;
   localparam int RECIP100_SHIFT = 19;
   localparam int DAYS_PER_YEAR  = 365;
   localparam int RD_BIAS        = 306;

   typedef enum logic [1:0] {
      FUNC_LOAD       = 2'd0,
      FUNC_ADD_DAYS   = 2'd1,
      FUNC_ADD_MONTHS = 2'd2,
      FUNC_ADD_YEARS  = 2'd3
   } func_type;

   typedef enum logic [8:0] {
      ST_IDLE  = 9'b000000001,
      ST_STEP  = 9'b000000010,
      ST_MMUL  = 9'b000000100,
      ST_MCOR  = 9'b000001000,
      ST_YMUL  = 9'b000010000,
      ST_YCOR  = 9'b000100000,
      ST_CLAMP = 9'b001000000,
      ST_RMUL  = 9'b010000000,
      ST_DONE  = 9'b100000000
   } state_type;

   // Length of month m; codes outside 1..12 give 31.
   function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] m,
                                               input logic leap);
      logic [DAY_W-1:0] len;
      unique case (m)
         4'd2:                     len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11:  len = 5'd30;
         default:                  len = 5'd31;
      endcase
      return len;
   endfunction

   // (153*mm - 457) / 5 with March as the first month of the counting year
   function automatic logic [MOFF_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
      logic [MOFF_W-1:0] off;
      unique case (m)
         4'd1:    off = 9'd306;
         4'd2:    off = 9'd337;
         4'd3:    off = 9'd0;
         4'd4:    off = 9'd31;
         4'd5:    off = 9'd61;
         4'd6:    off = 9'd92;
         4'd7:    off = 9'd122;
         4'd8:    off = 9'd153;
         4'd9:    off = 9'd184;
         4'd10:   off = 9'd214;
         4'd11:   off = 9'd245;
         4'd12:   off = 9'd275;
         default: off = 9'd0;
      endcase
      return off;
   endfunction

endpackage

// ----- sv/calendar_date_stepper.sv -----
// Gregorian date counter.
// Request channel (req_valid/req_ready): one transaction carries a function
// code and its operands: load a date (validated), or add a signed count of
// days, months or years to the held date.
// Response channel (rsp_valid/rsp_ready): exactly one transaction per
// request, carrying the date, its day number counted from 1 January of
// year 1, the leap flag, the month length and the range flag.
// Load and year steps pass through the year split, the day clamp and
// the day-number product; month steps divide by 12 first; day steps
// walk the date, stopping early at the first or last day of the year
// range, then form the day number. Day steps walk one day per cycle
// through the date registers; every other division (by 12 and by 100)
// and the day-number product share one multiplier, one use per cycle
// under the sequencer. One request is in work at a time: with a ready
// receiver the next request is taken in the cycle after the response
// loads.
// Reset returns the date to 1 January 2000 and empties the response
// register. When the receiver stalls, the response waits in its output
// register; the block still takes the next request and works it up to
// the point where its response would overwrite the waiting one.
module calendar_date_stepper #(
   parameter int MAX_YEAR   = 100000,
   parameter int DELTA_BITS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  cds_pkg::func_type                   req_func,
   input  logic [cds_pkg::LOAD_DAY_W-1:0]      req_load_day,
   input  logic [cds_pkg::MONTH_W-1:0]         req_load_month,
   input  logic [cds_pkg::YEAR_W-1:0]          req_load_year,
   input  logic signed [DELTA_BITS-1:0]        req_delta,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [cds_pkg::DAY_W-1:0]           rsp_day,
   output logic [cds_pkg::MONTH_W-1:0]         rsp_month,
   output logic [cds_pkg::YEAR_W-1:0]          rsp_year,
   output logic [cds_pkg::DN_W-1:0]            rsp_day_number,
   output logic                                rsp_leap_year,
   output logic [cds_pkg::DAY_W-1:0]           rsp_month_length,
   output logic                                rsp_out_of_range
);
   import cds_pkg::*;

   // widths for the month division: total = month - 1 + delta
   localparam int TW      = DELTA_BITS + 2;
   localparam int AW      = DELTA_BITS + 1;
   localparam int MW      = (AW > YEAR_W) ? AW : YEAR_W;
   localparam int NW      = MW + 2;
   localparam int RW      = DN_W + 1;
   localparam int RECIP12 = (1 << AW) / 12;

   localparam logic signed [NW-1:0]     NY_MAX   = NW'(MAX_YEAR);
   localparam logic [YEAR_W-1:0]        YEAR_MAX = YEAR_W'(MAX_YEAR);

   // sequencer and request hold
   state_type                 state_ff, state_in;
   func_type                  func_ff, func_in;
   logic signed [DELTA_BITS-1:0] delta_ff, delta_in;
   logic [LOAD_DAY_W-1:0]     ld_day_ff, ld_day_in;
   logic [DELTA_BITS-1:0]     cnt_ff, cnt_in;
   logic                      dir_ff, dir_in;
   logic                      flag_ff, flag_in;

   // held date, with year split as q100 * 100 + c100 for the leap rule
   logic [DAY_W-1:0]          day_ff, day_in;
   logic [MONTH_W-1:0]        month_ff, month_in;
   logic [YEAR_W-1:0]         year_ff, year_in;
   logic [C100_W-1:0]         c100_ff, c100_in;
   logic [Q100_W-1:0]         q100_ff, q100_in;

   // shared multiplier
   logic [MW-1:0]             mul_a, mul_b;
   logic [2*MW-1:0]           mul_ff, mul_in;
   logic                      mul_en;

   // response register
   logic                      rsp_valid_ff, rsp_valid_in;
   logic                      out_load;
   logic [DAY_W-1:0]          rsp_day_ff;
   logic [MONTH_W-1:0]        rsp_month_ff;
   logic [YEAR_W-1:0]         rsp_year_ff;
   logic [DN_W-1:0]           rsp_dn_ff;
   logic                      rsp_leap_ff;
   logic [DAY_W-1:0]          rsp_len_ff;
   logic                      rsp_oor_ff;

   // calendar helpers
   logic                      leap;
   logic [DAY_W-1:0]          len_cur, len_prev;

   // month step arithmetic
   logic signed [TW-1:0]      total;
   logic                      total_neg;
   logic [AW-1:0]             abs_total, q_est, r_est, r_fix, q_fix;
   logic                      r_ge;
   logic [MONTH_W-1:0]        mr, m_idx;
   logic signed [NW-1:0]      q_sgn, ny_m, ny_y, ny_sel, year_ext;
   logic                      ny_ok;
   logic [YEAR_W-1:0]         year_new;

   // year split arithmetic
   logic [Q100_W-1:0]         yq_est;
   logic [YEAR_W-1:0]         hundred, yr_est;
   logic                      yr_ge;

   // day number
   logic [YEAR_W-1:0]         yy;
   logic [Q100_W-1:0]         yq;
   logic [RW-1:0]             rd_sum;

   // Leap rule from the split year: divisible by 4, and not a century
   // unless the century count is divisible by 4.
   assign leap     = (year_ff[1:0] == 2'd0) && ((c100_ff != '0) || (q100_ff[1:0] == 2'd0));
   assign len_cur  = days_in(month_ff, leap);
   assign len_prev = days_in(month_ff - 4'd1, leap);

   // Month step: floor division of total by 12 through the reciprocal.
   assign total     = $signed({{(TW-MONTH_W){1'b0}}, month_ff}) - TW'(1)
                    + $signed({{(TW-DELTA_BITS){delta_ff[DELTA_BITS-1]}}, delta_ff});
   assign total_neg = total[TW-1];
   assign abs_total = total_neg ? AW'(-total) : AW'(total);

   always_comb begin
      q_est = mul_ff[AW +: AW];
      r_est = abs_total - (AW'({q_est, 3'b000}) + AW'({q_est, 2'b00}));
      r_ge  = (r_est >= AW'(12));
      r_fix = r_ge ? r_est - AW'(12) : r_est;
      q_fix = r_ge ? q_est + AW'(1) : q_est;
      mr    = r_fix[MONTH_W-1:0];
      if (!total_neg) begin
         q_sgn = $signed({{(NW-AW){1'b0}}, q_fix});
         m_idx = mr;
      end else if (mr != '0) begin
         // round toward minus infinity: borrow one year
         q_sgn = -($signed({{(NW-AW){1'b0}}, q_fix}) + NW'(1));
         m_idx = 4'd12 - mr;
      end else begin
         q_sgn = -$signed({{(NW-AW){1'b0}}, q_fix});
         m_idx = '0;
      end
   end

   // New year for month and year steps; out of range falls back to default.
   assign year_ext = $signed({{(NW-YEAR_W){1'b0}}, year_ff});
   assign ny_m     = year_ext + q_sgn;
   assign ny_y     = year_ext + $signed({{(NW-DELTA_BITS){req_delta[DELTA_BITS-1]}}, req_delta});
   assign ny_sel   = (state_ff == ST_MCOR) ? ny_m : ny_y;
   assign ny_ok    = !ny_sel[NW-1] && (ny_sel != '0) && (ny_sel <= NY_MAX);
   assign year_new = ny_ok ? ny_sel[YEAR_W-1:0] : DEFAULT_YEAR;

   // Year split: estimate from the product, fix with one compare and subtract.
   assign yq_est  = mul_ff[RECIP100_SHIFT +: Q100_W];
   assign hundred = YEAR_W'({yq_est, 6'b0}) + YEAR_W'({yq_est, 5'b0})
                  + YEAR_W'({yq_est, 2'b0});
   assign yr_est  = year_ff - hundred;
   assign yr_ge   = (yr_est >= YEAR_W'(100));

   // Day number: January and February count as months 13 and 14 of the
   // previous year.
   assign yy     = (month_ff < 4'd3) ? year_ff - YEAR_W'(1) : year_ff;
   assign yq     = ((month_ff < 4'd3) && (c100_ff == '0)) ? q100_ff - Q100_W'(1) : q100_ff;
   assign rd_sum = RW'(mul_ff) + RW'(yy >> 2) + RW'(yq >> 2)
                 + RW'(month_offset(month_ff)) + RW'(day_ff)
                 - RW'(yq) - RW'(RD_BIAS);

   // Multiplier operand select.
   always_comb begin
      mul_en = 1'b0;
      mul_a  = MW'(yy);
      mul_b  = MW'(DAYS_PER_YEAR);
      if (state_ff == ST_MMUL) begin
         mul_en = 1'b1;
         mul_a  = MW'(abs_total);
         mul_b  = MW'(RECIP12);
      end else if (state_ff == ST_YMUL) begin
         mul_en = 1'b1;
         mul_a  = MW'(year_ff);
         mul_b  = MW'(RECIP100);
      end else if (state_ff == ST_RMUL) begin
         mul_en = 1'b1;
      end
   end
   assign mul_in = mul_a * mul_b;

   assign req_ready = (state_ff == ST_IDLE);
   assign out_load  = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // Sequencer.
   always_comb begin
      state_in  = state_ff;
      func_in   = func_ff;
      delta_in  = delta_ff;
      ld_day_in = ld_day_ff;
      cnt_in    = cnt_ff;
      dir_in    = dir_ff;
      flag_in   = flag_ff;
      day_in    = day_ff;
      month_in  = month_ff;
      year_in   = year_ff;
      c100_in   = c100_ff;
      q100_in   = q100_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               delta_in  = req_delta;
               ld_day_in = req_load_day;
               flag_in   = 1'b0;
               unique case (req_func)
                  FUNC_LOAD: begin
                     year_in  = ((req_load_year != '0) && (req_load_year <= YEAR_MAX)) ?
                                req_load_year : DEFAULT_YEAR;
                     month_in = ((req_load_month >= 4'd1) && (req_load_month <= 4'd12)) ?
                                req_load_month : 4'd1;
                     state_in = ST_YMUL;
                  end
                  FUNC_ADD_DAYS: begin
                     dir_in   = req_delta[DELTA_BITS-1];
                     cnt_in   = req_delta[DELTA_BITS-1] ? DELTA_BITS'(-req_delta) :
                                DELTA_BITS'(req_delta);
                     state_in = ST_STEP;
                  end
                  FUNC_ADD_MONTHS: begin
                     state_in = ST_MMUL;
                  end
                  FUNC_ADD_YEARS: begin
                     year_in  = year_new;
                     state_in = ST_YMUL;
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_STEP: begin
            if (cnt_ff == '0) begin
               state_in = ST_RMUL;
            end else if (!dir_ff) begin
               cnt_in = cnt_ff - DELTA_BITS'(1);
               if (day_ff < len_cur) begin
                  day_in = day_ff + 5'd1;
               end else if (month_ff < 4'd12) begin
                  month_in = month_ff + 4'd1;
                  day_in   = 5'd1;
               end else if (year_ff >= YEAR_MAX) begin
                  // top of the range: drop the remaining steps
                  flag_in  = 1'b1;
                  state_in = ST_RMUL;
               end else begin
                  year_in  = year_ff + YEAR_W'(1);
                  month_in = 4'd1;
                  day_in   = 5'd1;
                  if (c100_ff == C100_W'(99)) begin
                     c100_in = '0;
                     q100_in = q100_ff + Q100_W'(1);
                  end else begin
                     c100_in = c100_ff + C100_W'(1);
                  end
               end
            end else begin
               cnt_in = cnt_ff - DELTA_BITS'(1);
               if (day_ff > 5'd1) begin
                  day_in = day_ff - 5'd1;
               end else if (month_ff > 4'd1) begin
                  month_in = month_ff - 4'd1;
                  day_in   = len_prev;
               end else if (year_ff <= YEAR_W'(1)) begin
                  // bottom of the range: drop the remaining steps
                  flag_in  = 1'b1;
                  state_in = ST_RMUL;
               end else begin
                  year_in  = year_ff - YEAR_W'(1);
                  month_in = 4'd12;
                  day_in   = 5'd31;
                  if (c100_ff == '0) begin
                     c100_in = C100_W'(99);
                     q100_in = q100_ff - Q100_W'(1);
                  end else begin
                     c100_in = c100_ff - C100_W'(1);
                  end
               end
            end
         end
         ST_MMUL: state_in = ST_MCOR;
         ST_MCOR: begin
            year_in  = year_new;
            month_in = m_idx + 4'd1;
            state_in = ST_YMUL;
         end
         ST_YMUL: state_in = ST_YCOR;
         ST_YCOR: begin
            c100_in  = yr_ge ? C100_W'(yr_est - YEAR_W'(100)) : C100_W'(yr_est);
            q100_in  = yr_ge ? yq_est + Q100_W'(1) : yq_est;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (func_ff == FUNC_LOAD) begin
               day_in = ((ld_day_ff != '0) && (ld_day_ff <= LOAD_DAY_W'(len_cur))) ?
                        ld_day_ff[DAY_W-1:0] : 5'd1;
            end else if (day_ff > len_cur) begin
               day_in = len_cur;
            end
            state_in = ST_RMUL;
         end
         ST_RMUL: state_in = ST_DONE;
         ST_DONE: begin
            if (out_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         func_ff      <= FUNC_LOAD;
         cnt_ff       <= '0;
         dir_ff       <= 1'b0;
         flag_ff      <= 1'b0;
         day_ff       <= 5'd1;
         month_ff     <= 4'd1;
         year_ff      <= DEFAULT_YEAR;
         c100_ff      <= '0;
         q100_ff      <= Q100_W'(20);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         func_ff      <= func_in;
         cnt_ff       <= cnt_in;
         dir_ff       <= dir_in;
         flag_ff      <= flag_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         c100_ff      <= c100_in;
         q100_ff      <= q100_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Operand holds, product and response payload.
   always_ff @(posedge clock) begin
      delta_ff  <= delta_in;
      ld_day_ff <= ld_day_in;
      if (mul_en) begin
         mul_ff <= mul_in;
      end
      if (out_load) begin
         rsp_day_ff   <= day_ff;
         rsp_month_ff <= month_ff;
         rsp_year_ff  <= year_ff;
         rsp_dn_ff    <= rd_sum[DN_W-1:0];
         rsp_leap_ff  <= leap;
         rsp_len_ff   <= len_cur;
         rsp_oor_ff   <= flag_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_day          = rsp_day_ff;
   assign rsp_month        = rsp_month_ff;
   assign rsp_year         = rsp_year_ff;
   assign rsp_day_number   = rsp_dn_ff;
   assign rsp_leap_year    = rsp_leap_ff;
   assign rsp_month_length = rsp_len_ff;
   assign rsp_out_of_range = rsp_oor_ff;

   // The year split must agree with the year whenever a request can start.
   a_year_split: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |->
         ((c100_ff < C100_W'(100)) &&
          (year_ff == YEAR_W'(q100_ff) * YEAR_W'(100) + YEAR_W'(c100_ff))))
      else $error("year split out of step with year");

   // The held date is a real date between requests and during day walks.
   a_date_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_IDLE) || (state_ff == ST_STEP)) |->
         ((month_ff >= 4'd1) && (month_ff <= 4'd12) &&
          (day_ff >= 5'd1) && (day_ff <= len_cur)))
      else $error("held date is not a valid date");

   // A response appears only out of the final sequencer step.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("response raised outside the final step");

   // The day walk counter only counts down.
   a_cnt_down: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_STEP) && $past(state_ff == ST_STEP)) |-> (cnt_ff <= $past(cnt_ff)))
      else $error("day step counter went up");

endmodule
